>>> sv/mbwfb_pkg.sv
// Shared types, constants and CRC helper for the Modbus RTU write frame builder.
package mbwfb_pkg;

	localparam int unsigned CfgIndexWidth = 2;
	localparam int unsigned FrameBytes    = 8;
	localparam int unsigned CrcSpan       = 6;
	localparam int unsigned IdxWidth      = $clog2(FrameBytes);

	// configuration register indexes
	localparam logic [CfgIndexWidth-1:0] CFG_SLAVE_ADDRESS = 2'd0;
	localparam logic [CfgIndexWidth-1:0] CFG_FUNCTION_CODE = 2'd1;

	localparam logic [7:0]  SLAVE_ADDRESS_RST = 8'h01;
	localparam logic [7:0]  FUNCTION_CODE_RST = 8'h06;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// frame byte positions
	localparam logic [IdxWidth-1:0] POS_CRC_HI = 3'd6;
	localparam logic [IdxWidth-1:0] POS_LAST   = 3'd7;

	typedef struct packed {
		logic [CrcSpan-1:0][7:0] bytes;   // bytes[0] goes out first
		logic [15:0]             crc;     // running CRC over the bytes done so far
	} frame_t;

	// one byte through the reflected CRC-16, LSB first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
		logic [15:0] acc;
		acc = crc_in ^ {8'h00, data};
		for (int b = 0; b < 8; b++) begin
			if (acc[0]) begin
				acc = (acc >> 1) ^ CRC_POLY;
			end else begin
				acc = acc >> 1;
			end
		end
		return acc;
	endfunction

endpackage

>>> sv/mbwfb_crc_stage.sv
// One pipeline stage folding two frame bytes into the running CRC.
module mbwfb_crc_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  mbwfb_pkg::frame_t    in_frame,
	input  logic [7:0]           first_byte,
	input  logic [7:0]           second_byte,
	output logic                 out_valid,
	input  logic                 out_stall,
	output mbwfb_pkg::frame_t    out_frame
);

	logic              valid_s;
	mbwfb_pkg::frame_t frame_s;
	mbwfb_pkg::frame_t frame_d;

	assign in_stall = valid_s && out_stall;

	always_comb begin
		frame_d     = in_frame;
		frame_d.crc = mbwfb_pkg::crc_byte(mbwfb_pkg::crc_byte(in_frame.crc, first_byte),
			second_byte);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= 1'b0;
		end else if (!in_stall) begin
			valid_s <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			frame_s <= frame_d;
		end
	end

	assign out_valid = valid_s;
	assign out_frame = frame_s;

endmodule

>>> sv/mbwfb_serializer.sv
// Holds one finished frame and sends it out a byte a cycle while out_stall is low.
module mbwfb_serializer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  mbwfb_pkg::frame_t    in_frame,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           out_byte,
	output logic                 out_last
);

	logic                              valid_q;
	logic [mbwfb_pkg::IdxWidth-1:0]    idx_q;
	mbwfb_pkg::frame_t                 frame_q;
	logic                              out_take;
	logic                              at_last;

	assign at_last  = (idx_q == mbwfb_pkg::POS_LAST);
	assign out_take = valid_q && !out_stall;
	assign in_stall = valid_q && !(out_take && at_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (!in_stall) begin
			valid_q <= in_valid;
			idx_q   <= '0;
		end else if (out_take) begin
			idx_q   <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			frame_q <= in_frame;
		end
	end

	always_comb begin
		case (idx_q)
			mbwfb_pkg::POS_CRC_HI: out_byte = frame_q.crc[15:8];
			mbwfb_pkg::POS_LAST:   out_byte = frame_q.crc[7:0];
			default:               out_byte = frame_q.bytes[idx_q];
		endcase
	end

	assign out_valid = valid_q;
	assign out_last  = at_last;

endmodule

>>> sv/modbus_rtu_write_frame_builder_unit.sv
// Top level: Modbus RTU write-single-register frame builder with CRC-16.
// Pipeline: the request word is registered in three CRC stages of two bytes each, then
//   in the byte serialiser, which offers the first frame byte.
// Throughput: the serialiser sends eight bytes at one byte per cycle while byte_stall is
//   low; the CRC stages take a word every cycle unless stalled from behind.
// Reset (arst_n, asynchronous, active low) empties the pipeline and sets the slave
//   address to 1 and the function code to 6.
module modbus_rtu_write_frame_builder_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration write channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [mbwfb_pkg::CfgIndexWidth-1:0]  cfg_index,
	input  logic [7:0]                           cfg_data,
	// request words
	input  logic                                 req_valid,
	output logic                                 req_stall,
	input  logic [15:0]                          register_address,
	input  logic [15:0]                          register_value,
	// frame byte words
	output logic                                 byte_valid,
	input  logic                                 byte_stall,
	output logic [7:0]                           frame_byte,
	output logic                                 last_byte
);

	logic [7:0] slave_address_q;
	logic [7:0] function_code_q;

	mbwfb_pkg::frame_t frame_in;
	mbwfb_pkg::frame_t frame_a;
	mbwfb_pkg::frame_t frame_b;
	mbwfb_pkg::frame_t frame_c;
	logic valid_a, valid_b, valid_c;
	logic stall_a, stall_b, stall_c;

	// Config is always taken; writes to unknown indexes are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_address_q <= mbwfb_pkg::SLAVE_ADDRESS_RST;
			function_code_q <= mbwfb_pkg::FUNCTION_CODE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				mbwfb_pkg::CFG_SLAVE_ADDRESS: slave_address_q <= cfg_data;
				mbwfb_pkg::CFG_FUNCTION_CODE: function_code_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Assemble the six header/data bytes; CRC starts at its seed.
	always_comb begin
		frame_in.bytes[0] = slave_address_q;
		frame_in.bytes[1] = function_code_q;
		frame_in.bytes[2] = register_address[15:8];
		frame_in.bytes[3] = register_address[7:0];
		frame_in.bytes[4] = register_value[15:8];
		frame_in.bytes[5] = register_value[7:0];
		frame_in.crc      = mbwfb_pkg::CRC_INIT;
	end

	// Stage 1: address and function code.
	mbwfb_crc_stage u_crc_s1 (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (req_valid),
		.in_stall    (req_stall),
		.in_frame    (frame_in),
		.first_byte  (frame_in.bytes[0]),
		.second_byte (frame_in.bytes[1]),
		.out_valid   (valid_a),
		.out_stall   (stall_a),
		.out_frame   (frame_a)
	);

	// Stage 2: register address.
	mbwfb_crc_stage u_crc_s2 (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (valid_a),
		.in_stall    (stall_a),
		.in_frame    (frame_a),
		.first_byte  (frame_a.bytes[2]),
		.second_byte (frame_a.bytes[3]),
		.out_valid   (valid_b),
		.out_stall   (stall_b),
		.out_frame   (frame_b)
	);

	// Stage 3: register value; CRC complete afterwards.
	mbwfb_crc_stage u_crc_s3 (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (valid_b),
		.in_stall    (stall_b),
		.in_frame    (frame_b),
		.first_byte  (frame_b.bytes[4]),
		.second_byte (frame_b.bytes[5]),
		.out_valid   (valid_c),
		.out_stall   (stall_c),
		.out_frame   (frame_c)
	);

	// Serialiser: six bytes, then CRC high, then CRC low flagged as last.
	mbwfb_serializer u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_c),
		.in_stall  (stall_c),
		.in_frame  (frame_c),
		.out_valid (byte_valid),
		.out_stall (byte_stall),
		.out_byte  (frame_byte),
		.out_last  (last_byte)
	);

endmodule

>>> tb/tb_modbus_rtu_write_frame_builder_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Modbus RTU write frame builder: predicted frames vs DUT bytes.

module tb_modbus_rtu_write_frame_builder_unit;

	// indexes with no register behind them; writes there must change nothing
	localparam logic [mbwfb_pkg::CfgIndexWidth-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [mbwfb_pkg::CfgIndexWidth-1:0] CFG_SPARE_3 = 2'd3;

	localparam int RandomWords  = 214;
	localparam int SegmentWords = 58;   // random words between two register settings
	localparam int LongHold     = 150;  // cycles the byte side holds off once

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} frame_word_t;

	// Register copy, frame predictor and the queue of bytes still owed by the DUT.
	class frame_checker;
		logic [7:0]  slave_addr;
		logic [7:0]  func_code;
		frame_word_t owed[$];
		int unsigned fails;

		function new();
			slave_addr = mbwfb_pkg::SLAVE_ADDRESS_RST;
			func_code  = mbwfb_pkg::FUNCTION_CODE_RST;
			fails      = 0;
		endfunction

		function void write_reg(logic [mbwfb_pkg::CfgIndexWidth-1:0] idx, logic [7:0] data);
			case (idx)
				mbwfb_pkg::CFG_SLAVE_ADDRESS: slave_addr = data;
				mbwfb_pkg::CFG_FUNCTION_CODE: func_code  = data;
				default: ;
			endcase
		endfunction

		// one request word gives eight bytes; CRC run bit-serially, LSB of each byte first
		function void note_request(logic [15:0] addr, logic [15:0] val);
			logic [7:0]  frame [mbwfb_pkg::FrameBytes];
			logic [15:0] crc;
			frame[0] = slave_addr;
			frame[1] = func_code;
			frame[2] = addr[15:8];
			frame[3] = addr[7:0];
			frame[4] = val[15:8];
			frame[5] = val[7:0];
			crc = mbwfb_pkg::CRC_INIT;
			for (int k = 0; k < mbwfb_pkg::CrcSpan; k++) begin
				for (int b = 0; b < 8; b++) begin
					if (crc[0] ^ frame[k][b]) begin
						crc = (crc >> 1) ^ mbwfb_pkg::CRC_POLY;
					end else begin
						crc = crc >> 1;
					end
				end
			end
			// CRC high byte goes out first here, low byte closes the frame
			frame[6] = crc[15:8];
			frame[7] = crc[7:0];
			for (int k = 0; k < mbwfb_pkg::FrameBytes; k++) begin
				owed.push_back('{data: frame[k], last: (k == mbwfb_pkg::FrameBytes - 1)});
			end
		endfunction

		function void check_byte(logic [7:0] data, logic last);
			frame_word_t want;
			if (owed.size() == 0) begin
				$error("frame_byte %02h arrived with no request outstanding", data);
				fails++;
				return;
			end
			want = owed.pop_front();
			if (data !== want.data) begin
				$error("frame_byte: expected %02h, got %02h", want.data, data);
				fails++;
			end
			if (last !== want.last) begin
				$error("last_byte: expected %0b, got %0b", want.last, last);
				fails++;
			end
		endfunction

		function bit drained();
			return owed.size() == 0;
		endfunction
	endclass

	logic                                clk;
	logic                                arst_n;
	logic                                cfg_valid;
	logic                                cfg_ready;
	logic [mbwfb_pkg::CfgIndexWidth-1:0] cfg_index;
	logic [7:0]                          cfg_data;
	logic                                req_valid;
	logic                                req_stall;
	logic [15:0]                         register_address;
	logic [15:0]                         register_value;
	logic                                byte_valid;
	logic                                byte_stall;
	logic [7:0]                          frame_byte;
	logic                                last_byte;

	frame_checker frames = new();

	// idle-free stretch for both sides, and the one-off long hold on the byte side
	bit calm_in;
	bit calm_out;
	bit long_hold_req;

	modbus_rtu_write_frame_builder_unit dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.req_valid        (req_valid),
		.req_stall        (req_stall),
		.register_address (register_address),
		.register_value   (register_value),
		.byte_valid       (byte_valid),
		.byte_stall       (byte_stall),
		.frame_byte       (frame_byte),
		.last_byte        (last_byte)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Offer one request word, with the odd idle cycle first; returns on the accepting edge.
	// Valid is left high so back-to-back words never see a low/high pair in one step.
	task automatic send_request(input logic [15:0] addr, input logic [15:0] val);
		while (!calm_in && $urandom_range(99) < 6) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid        <= 1'b1;
		register_address <= addr;
		register_value   <= val;
		do @(posedge clk); while (req_stall);
		frames.note_request(addr, val);
	endtask

	// Leaves cfg_valid high; the caller drops it after the last write of a batch.
	task automatic write_reg(input logic [mbwfb_pkg::CfgIndexWidth-1:0] idx,
		input logic [7:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		frames.write_reg(idx, data);
	endtask

	// Both registers, then a stray write to a spare index that must be ignored.
	task automatic configure(input logic [7:0] slave, input logic [7:0] func);
		write_reg(mbwfb_pkg::CFG_SLAVE_ADDRESS, slave);
		write_reg(mbwfb_pkg::CFG_FUNCTION_CODE, func);
		write_reg($urandom_range(1) ? CFG_SPARE_2 : CFG_SPARE_3, 8'($urandom_range(255)));
		cfg_valid <= 1'b0;
	endtask

	// Stop offering, wait for every owed byte, then a short pause so the block is truly idle.
	task automatic wait_drained();
		req_valid <= 1'b0;
		while (!frames.drained()) @(posedge clk);
		repeat (mbwfb_pkg::FrameBytes + 4) @(posedge clk);
	endtask

	// Mostly uniform, with the all-zeros and all-ones corners showing up now and then.
	function automatic logic [15:0] rand_field();
		case ($urandom_range(9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(16'hFFFF));
		endcase
	endfunction

	// Byte side: check each accepted word, then pick next cycle's stall.
	initial begin
		int hold_left;
		hold_left = 0;
		byte_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && byte_valid && !byte_stall) begin
				frames.check_byte(frame_byte, last_byte);
			end
			if (long_hold_req) begin
				hold_left     = LongHold;
				long_hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				byte_stall <= 1'b1;
			end else begin
				byte_stall <= !calm_out && ($urandom_range(99) < 6);
			end
		end
	end

	// Stimulus
	initial begin
		calm_in          = 1'b0;
		calm_out         = 1'b0;
		long_hold_req    = 1'b0;
		arst_n           <= 1'b0;
		cfg_valid        <= 1'b0;
		cfg_index        <= mbwfb_pkg::CFG_SLAVE_ADDRESS;
		cfg_data         <= 8'h00;
		req_valid        <= 1'b0;
		register_address <= 16'h0000;
		register_value   <= 16'h0000;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: slave 1, function 6
		send_request(16'h0001, 16'h0003);
		send_request(16'h0000, 16'h0000);
		send_request(16'hFFFF, 16'hFFFF);
		send_request(16'h0000, 16'hFFFF);
		send_request(16'hFFFF, 16'h0000);
		send_request(16'hAAAA, 16'h5555);
		send_request(16'h5555, 16'hAAAA);
		send_request(16'h8000, 16'h0001);
		wait_drained();

		// register extremes one way round...
		configure(8'hFF, 8'h00);
		send_request(16'h0000, 16'h0000);
		send_request(16'hFFFF, 16'hFFFF);
		send_request(16'h1234, 16'hABCD);
		send_request(16'h00FF, 16'hFF00);
		wait_drained();

		// ...and the other
		configure(8'h00, 8'hFF);
		send_request(16'hFFFF, 16'h0000);
		send_request(16'h0000, 16'hFFFF);
		send_request(16'h0001, 16'h8000);
		send_request(16'hFEDC, 16'h0123);
		wait_drained();

		// random words in segments, new random settings per segment;
		// early on the byte side holds off long enough to back the block up
		for (int n = 0; n < RandomWords; n++) begin
			if (n % SegmentWords == 0) begin
				if (n != 0) begin
					wait_drained();
				end
				configure(8'($urandom_range(255)), 8'($urandom_range(255)));
			end
			if (n == 10) begin
				long_hold_req = 1'b1;
			end
			calm_in  = (n >= 100 && n < 160);
			calm_out = calm_in;
			send_request(rand_field(), rand_field());
		end

		req_valid <= 1'b0;
		while (!frames.drained()) @(posedge clk);
		repeat (16) @(posedge clk);
		if (frames.fails == 0 && frames.drained()) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#500000;
		$display("Some tests failed");
		$finish;
	end

endmodule

>>> sim.f
sv/mbwfb_pkg.sv
sv/mbwfb_crc_stage.sv
sv/mbwfb_serializer.sv
sv/modbus_rtu_write_frame_builder_unit.sv
tb/tb_modbus_rtu_write_frame_builder_unit.sv
